### rtl/core/exprtok_pkg.sv
// Shared types, character codes and helper functions for the expression tokenizer.
// No dependencies; every other file of the block refers to this package by scoped names.

package exprtok_pkg;

  localparam int unsigned PositionWidthDefault = 16;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned KindWidth = 3;
  localparam int unsigned RadixWidth = 5;
  localparam int unsigned ErrWidth = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  typedef logic [CharWidth-1:0] char_t;
  typedef logic [FieldWidth-1:0] field_t;
  typedef logic [RadixWidth-1:0] radix_t;

  typedef enum logic [2:0] {
    ModeIdle      = 3'd0,
    ModeName      = 3'd1,
    ModeDec       = 3'd2,
    ModeHexStart  = 3'd3,
    ModeHex       = 3'd4,
    ModeBaseStart = 3'd5,
    ModeBaseN     = 3'd6,
    ModeError     = 3'd7
  } mode_e;

  typedef enum logic [KindWidth-1:0] {
    KindNumber = 3'd0,
    KindName   = 3'd1,
    KindSymbol = 3'd2,
    KindLParen = 3'd3,
    KindRParen = 3'd4,
    KindSep    = 3'd5,
    KindEnd    = 3'd6
  } kind_e;

  typedef enum logic [ErrWidth-1:0] {
    ErrNone     = 2'd0,
    ErrUnknown  = 2'd1,
    ErrBadDigit = 2'd2
  } err_e;

  localparam radix_t RadixNone = 5'd0;
  localparam radix_t RadixDec  = 5'd10;
  localparam radix_t RadixHex  = 5'd16;

  localparam char_t CharNul    = 8'h00;
  localparam char_t CharTab    = 8'h09;
  localparam char_t CharCr     = 8'h0D;
  localparam char_t CharSpace  = 8'h20;
  localparam char_t CharLParen = "(";
  localparam char_t CharRParen = ")";
  localparam char_t CharComma  = ",";
  localparam char_t CharPlus   = "+";
  localparam char_t CharMinus  = "-";
  localparam char_t CharStar   = "*";
  localparam char_t CharCaret  = "^";
  localparam char_t CharDot    = ".";
  localparam char_t CharLowX   = "x";
  localparam char_t CharUnder  = "_";
  localparam char_t CharZero   = "0";
  localparam char_t CharNine   = "9";
  localparam char_t CharLowA   = "a";
  localparam char_t CharLowF   = "f";
  localparam char_t CharLowZ   = "z";
  localparam char_t CharUpA    = "A";
  localparam char_t CharUpF    = "F";
  localparam char_t CharUpZ    = "Z";

  typedef struct packed {
    kind_e  kind;
    field_t start;
    field_t length;
    radix_t radix;
    err_e   err;
  } result_t;

  // One queue entry holds every result caused by one character.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  function automatic logic is_digit(char_t c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_alpha(char_t c);
    return ((c >= CharLowA) && (c <= CharLowZ)) || ((c >= CharUpA) && (c <= CharUpZ));
  endfunction

  function automatic logic is_xdigit(char_t c);
    return is_digit(c) || ((c >= CharLowA) && (c <= CharLowF)) ||
           ((c >= CharUpA) && (c <= CharUpF));
  endfunction

  function automatic logic is_space(char_t c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic result_t make_result(kind_e kind, field_t start, field_t length,
                                          radix_t radix, err_e err);
    result_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.radix  = radix;
    r.err    = err;
    return r;
  endfunction

endpackage

### rtl/core/exprtok_intf.sv
// Handshake interfaces for the character input and the token output channels.
// Depends on exprtok_pkg for the field widths.

interface exprtok_char_if;
  logic                                valid;
  logic                                ready;
  logic [exprtok_pkg::CharWidth-1:0]   char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface exprtok_tok_if;
  logic                                valid;
  logic                                ready;
  logic [exprtok_pkg::KindWidth-1:0]   token_kind;
  logic [exprtok_pkg::FieldWidth-1:0]  token_start;
  logic [exprtok_pkg::FieldWidth-1:0]  token_length;
  logic [exprtok_pkg::RadixWidth-1:0]  number_radix;
  logic [exprtok_pkg::ErrWidth-1:0]    error_code;
  logic                                last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output number_radix, output error_code, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input number_radix, input error_code, input last_of_run, output ready);
endinterface

### rtl/core/exprtok_front.sv
// Front end: accepts characters, runs the lexer state and builds one queue entry per
// character that yields results. Depends on exprtok_pkg and exprtok_char_if.

module exprtok_front #(
  parameter int unsigned PositionWidth = exprtok_pkg::PositionWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  exprtok_char_if.sink          char_i,
  input  logic                  full_i,
  output logic                  push_o,
  output exprtok_pkg::entry_t   entry_o
);

  localparam logic [PositionWidth-1:0] CountOne = {{(PositionWidth-1){1'b0}}, 1'b1};

  exprtok_pkg::mode_e         mode_q, mode_d;
  logic [PositionWidth-1:0]   pos_q, pos_d;
  logic [PositionWidth-1:0]   begin_q, begin_d;
  logic [PositionWidth-1:0]   cnt_q, cnt_d;
  exprtok_pkg::radix_t        radix_q, radix_d;
  logic                       frac_q, frac_d;

  exprtok_pkg::char_t         c;
  logic                       accept;
  logic [PositionWidth-1:0]   grown;
  exprtok_pkg::field_t        p16, begin16, cnt16;
  exprtok_pkg::radix_t        digit_val;
  logic                       base_ok;
  logic                       relex;
  logic                       first_v, second_v;
  exprtok_pkg::result_t       first_r, second_r;

  assign c         = char_i.char_in;
  assign char_i.ready = !full_i;
  assign accept    = char_i.valid && !full_i;
  assign grown     = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign p16       = exprtok_pkg::field_t'(pos_q);
  assign begin16   = exprtok_pkg::field_t'(begin_q);
  assign cnt16     = exprtok_pkg::field_t'(cnt_q);
  assign digit_val = {1'b0, c[3:0]};
  assign base_ok   = exprtok_pkg::is_digit(c) && (digit_val < radix_q);

  always_comb begin
    mode_d   = mode_q;
    begin_d  = begin_q;
    cnt_d    = cnt_q;
    radix_d  = radix_q;
    frac_d   = frac_q;
    relex    = 1'b0;
    first_v  = 1'b0;
    second_v = 1'b0;
    first_r  = exprtok_pkg::make_result(exprtok_pkg::KindEnd, p16, exprtok_pkg::field_t'(1),
                                        exprtok_pkg::RadixNone, exprtok_pkg::ErrNone);
    second_r = first_r;

    unique case (mode_q)
      exprtok_pkg::ModeIdle: begin
        relex = 1'b1;
      end
      exprtok_pkg::ModeName: begin
        if (exprtok_pkg::is_alpha(c) || exprtok_pkg::is_digit(c) ||
            (c == exprtok_pkg::CharUnder)) begin
          cnt_d = grown;
        end else begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindName, begin16, cnt16,
                                             exprtok_pkg::RadixNone, exprtok_pkg::ErrNone);
          relex   = 1'b1;
        end
      end
      exprtok_pkg::ModeDec: begin
        priority if (exprtok_pkg::is_digit(c)) begin
          cnt_d = grown;
        end else if ((c == exprtok_pkg::CharDot) && !frac_q) begin
          frac_d = 1'b1;
          cnt_d  = grown;
        end else if ((c == exprtok_pkg::CharLowX) && (cnt_q == CountOne) && !frac_q) begin
          cnt_d = grown;
          if (radix_q == exprtok_pkg::RadixNone) begin
            radix_d = exprtok_pkg::RadixHex;
            mode_d  = exprtok_pkg::ModeHexStart;
          end else begin
            mode_d = exprtok_pkg::ModeBaseStart;
          end
        end else begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindNumber, begin16, cnt16,
                                             exprtok_pkg::RadixDec, exprtok_pkg::ErrNone);
          relex   = 1'b1;
        end
      end
      exprtok_pkg::ModeHexStart: begin
        if (exprtok_pkg::is_xdigit(c)) begin
          cnt_d  = grown;
          mode_d = exprtok_pkg::ModeHex;
        end else begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindEnd, begin16, cnt16,
                                             exprtok_pkg::RadixNone, exprtok_pkg::ErrUnknown);
          mode_d  = exprtok_pkg::ModeError;
        end
      end
      exprtok_pkg::ModeHex: begin
        priority if (exprtok_pkg::is_xdigit(c)) begin
          cnt_d = grown;
        end else if ((c == exprtok_pkg::CharDot) && !frac_q) begin
          frac_d = 1'b1;
          cnt_d  = grown;
        end else begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindNumber, begin16, cnt16,
                                             exprtok_pkg::RadixHex, exprtok_pkg::ErrNone);
          relex   = 1'b1;
        end
      end
      exprtok_pkg::ModeBaseStart, exprtok_pkg::ModeBaseN: begin
        priority if (base_ok) begin
          cnt_d  = grown;
          mode_d = exprtok_pkg::ModeBaseN;
        end else if ((c == exprtok_pkg::CharDot) && (mode_q == exprtok_pkg::ModeBaseN) &&
                     !frac_q) begin
          frac_d = 1'b1;
          cnt_d  = grown;
        end else if (exprtok_pkg::is_xdigit(c)) begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindEnd, p16,
                                             exprtok_pkg::field_t'(1),
                                             exprtok_pkg::RadixNone,
                                             exprtok_pkg::ErrBadDigit);
          mode_d  = exprtok_pkg::ModeError;
        end else begin
          first_v = 1'b1;
          first_r = exprtok_pkg::make_result(exprtok_pkg::KindNumber, begin16, cnt16,
                                             radix_q, exprtok_pkg::ErrNone);
          relex   = 1'b1;
        end
      end
      exprtok_pkg::ModeError: begin
        if (c == exprtok_pkg::CharNul) begin
          first_v = 1'b1;
        end
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    // A character in the idle state, or one that closed a token, is lexed from idle.
    if (relex) begin
      mode_d = exprtok_pkg::ModeIdle;
      priority if (exprtok_pkg::is_space(c)) begin
        second_v = 1'b0;
      end else if (c == exprtok_pkg::CharLParen) begin
        second_v = 1'b1;
        second_r.kind = exprtok_pkg::KindLParen;
      end else if (c == exprtok_pkg::CharRParen) begin
        second_v = 1'b1;
        second_r.kind = exprtok_pkg::KindRParen;
      end else if (c == exprtok_pkg::CharComma) begin
        second_v = 1'b1;
        second_r.kind = exprtok_pkg::KindSep;
      end else if (c == exprtok_pkg::CharNul) begin
        second_v = 1'b1;
      end else if ((c == exprtok_pkg::CharPlus) || (c == exprtok_pkg::CharMinus) ||
                   (c == exprtok_pkg::CharStar) || (c == exprtok_pkg::CharCaret)) begin
        second_v = 1'b1;
        second_r.kind = exprtok_pkg::KindSymbol;
      end else if (exprtok_pkg::is_alpha(c) || (c == exprtok_pkg::CharUnder)) begin
        mode_d  = exprtok_pkg::ModeName;
        begin_d = pos_q;
        cnt_d   = CountOne;
        frac_d  = 1'b0;
      end else if (exprtok_pkg::is_digit(c)) begin
        mode_d  = exprtok_pkg::ModeDec;
        begin_d = pos_q;
        cnt_d   = CountOne;
        frac_d  = 1'b0;
        radix_d = digit_val;
      end else begin
        second_v     = 1'b1;
        second_r.err = exprtok_pkg::ErrUnknown;
        mode_d       = exprtok_pkg::ModeError;
      end
    end

    if (c == exprtok_pkg::CharNul) begin
      mode_d = exprtok_pkg::ModeIdle;
      pos_d  = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign push_o        = accept && (first_v || second_v);
  assign entry_o.two   = first_v && second_v;
  assign entry_o.first = first_v ? first_r : second_r;
  assign entry_o.second = second_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= exprtok_pkg::ModeIdle;
      pos_q   <= '0;
      begin_q <= '0;
      cnt_q   <= '0;
      radix_q <= exprtok_pkg::RadixNone;
      frac_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      cnt_q   <= cnt_d;
      radix_q <= radix_d;
      frac_q  <= frac_d;
    end
  end

  // A terminator always restarts the position count.
  a_nul_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (c == exprtok_pkg::CharNul)) |=> (pos_q == '0))
    else $error("position not cleared after terminator");

  // A bad-digit entry always leaves the lexer in the error state.
  a_bad_digit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (entry_o.first.err == exprtok_pkg::ErrBadDigit)) |=>
    (mode_q == exprtok_pkg::ModeError))
    else $error("bad digit did not enter error state");

  // The base-N states only exist with a nonzero base below ten.
  a_base_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == exprtok_pkg::ModeBaseStart) || (mode_q == exprtok_pkg::ModeBaseN)) |->
    ((radix_q != exprtok_pkg::RadixNone) && (radix_q < exprtok_pkg::RadixDec)))
    else $error("base-N state with invalid radix");

endmodule

### rtl/core/exprtok_fifo.sv
// Short queue of per-character result entries between the front and back ends.
// Depends on exprtok_pkg for the entry type and queue depth.

module exprtok_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  exprtok_pkg::entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output exprtok_pkg::entry_t  entry_o,
  output logic                 empty_o
);

  exprtok_pkg::entry_t                        mem_q [exprtok_pkg::QueueDepth];
  logic [exprtok_pkg::QueuePtrWidth-1:0]      wr_ptr_q, rd_ptr_q;
  logic [exprtok_pkg::QueueCntWidth-1:0]      cnt_q;

  assign full_o  = (cnt_q == exprtok_pkg::QueueCntWidth'(exprtok_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

### rtl/core/exprtok_back.sv
// Back end: takes queue entries and presents their results one beat at a time
// from an output register. Depends on exprtok_pkg and exprtok_tok_if.

module exprtok_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  exprtok_pkg::entry_t  entry_i,
  output logic                 pop_o,
  exprtok_tok_if.source        token_o
);

  logic                  valid_q;
  logic                  phase_q;
  exprtok_pkg::entry_t   cur_q;
  exprtok_pkg::result_t  res;
  logic                  take;
  logic                  last;

  assign take  = valid_q && token_o.ready;
  assign last  = !cur_q.two || phase_q;
  assign pop_o = !empty_i && (!valid_q || (take && last));
  assign res   = phase_q ? cur_q.second : cur_q.first;

  assign token_o.valid        = valid_q;
  assign token_o.token_kind   = res.kind;
  assign token_o.token_start  = res.start;
  assign token_o.token_length = res.length;
  assign token_o.number_radix = res.radix;
  assign token_o.error_code   = res.err;
  assign token_o.last_of_run  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      phase_q <= 1'b0;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  a_second_only_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && phase_q) |-> cur_q.two)
    else $error("second beat shown for a single-result entry");

  a_pair_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=> (valid_q && phase_q))
    else $error("second beat of a pair was lost");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !token_o.ready) |=> (valid_q && $stable(phase_q)))
    else $error("output beat dropped while stalled");

endmodule

### rtl/core/expression_tokenizer.sv
// Expression tokenizer: one character per beat in, token beats out.
// The first result beat of a character passes through the queue and then the output
// register. Throughput: one character per cycle while the queue is not full; a character
// that closes a token and also yields its own token gives two result beats, which the
// two-entry queue absorbs.
// Reset: lexer idle, position and token counters zero, queue and output register empty.
// Depends on exprtok_pkg, exprtok_intf, exprtok_front, exprtok_fifo and exprtok_back.

module expression_tokenizer #(
  parameter int unsigned PositionWidth = exprtok_pkg::PositionWidthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  exprtok_char_if.sink    char_i,
  exprtok_tok_if.source   token_o
);

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  exprtok_pkg::entry_t  push_entry;
  exprtok_pkg::entry_t  pop_entry;

  exprtok_front #(
    .PositionWidth (PositionWidth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  exprtok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  exprtok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .token_o (token_o)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for expression_tokenizer: character beats in, token beats checked
// against an in-bench lexer model. Depends on exprtok_pkg, the exprtok interfaces and the RTL.

module tb;

  typedef struct packed {
    exprtok_pkg::result_t res;
    logic                 last;
  } token_beat_t;

  localparam string LeadSet  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string NameSet  = "abcxyzABCXYZ_0123456789qQ";
  localparam string DecSet   = "0123456789";
  localparam string HexSet   = "0123456789abcdefABCDEF";
  localparam string OpSet    = "+-*^(),";
  localparam string BlankSet = " \t\v\f \n";

  logic clk;
  logic rst_n;

  exprtok_char_if char_bus ();
  exprtok_tok_if  tok_bus ();

  expression_tokenizer DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_bus),
    .token_o(tok_bus)
  );

  exprtok_pkg::mode_e   lex_mode;
  exprtok_pkg::field_t  lex_pos;
  exprtok_pkg::field_t  lex_begin;
  exprtok_pkg::field_t  lex_len;
  exprtok_pkg::radix_t  lex_radix;
  logic                 lex_frac;

  exprtok_pkg::result_t step_tokens[$];
  token_beat_t          pending_tokens[$];
  exprtok_pkg::char_t   expr_chars[$];

  int unsigned mismatches;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("expression_tokenizer regression: fail");
    $finish;
  end

  function automatic bit ch_digit(exprtok_pkg::char_t c);
    return (c >= exprtok_pkg::CharZero) && (c <= exprtok_pkg::CharNine);
  endfunction

  function automatic bit ch_alpha(exprtok_pkg::char_t c);
    return ((c >= exprtok_pkg::CharLowA) && (c <= exprtok_pkg::CharLowZ)) ||
           ((c >= exprtok_pkg::CharUpA) && (c <= exprtok_pkg::CharUpZ));
  endfunction

  function automatic bit ch_hex(exprtok_pkg::char_t c);
    return ch_digit(c) || ((c >= exprtok_pkg::CharLowA) && (c <= exprtok_pkg::CharLowF)) ||
           ((c >= exprtok_pkg::CharUpA) && (c <= exprtok_pkg::CharUpF));
  endfunction

  function automatic bit ch_blank(exprtok_pkg::char_t c);
    return (c == exprtok_pkg::CharSpace) ||
           ((c >= exprtok_pkg::CharTab) && (c <= exprtok_pkg::CharCr));
  endfunction

  function automatic exprtok_pkg::char_t pick(string set);
    return exprtok_pkg::char_t'(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic void add_token(exprtok_pkg::kind_e k, exprtok_pkg::field_t s,
                                    exprtok_pkg::field_t l, exprtok_pkg::radix_t r,
                                    exprtok_pkg::err_e e);
    step_tokens.push_back(exprtok_pkg::make_result(k, s, l, r, e));
  endfunction

  function automatic void add_single(exprtok_pkg::kind_e k, exprtok_pkg::field_t s,
                                     exprtok_pkg::err_e e);
    add_token(k, s, 16'd1, exprtok_pkg::RadixNone, e);
  endfunction

  function automatic void grow_len();
    if (lex_len != 16'hFFFF) lex_len++;
  endfunction

  function automatic void open_token(exprtok_pkg::mode_e m, exprtok_pkg::field_t p);
    lex_mode = m;
    lex_begin = p;
    lex_len = 16'd1;
    lex_frac = 1'b0;
  endfunction

  function automatic void lex_fresh(exprtok_pkg::char_t c, exprtok_pkg::field_t p);
    lex_mode = exprtok_pkg::ModeIdle;
    if (ch_blank(c)) return;
    case (c)
      exprtok_pkg::CharLParen: add_single(exprtok_pkg::KindLParen, p, exprtok_pkg::ErrNone);
      exprtok_pkg::CharRParen: add_single(exprtok_pkg::KindRParen, p, exprtok_pkg::ErrNone);
      exprtok_pkg::CharComma:  add_single(exprtok_pkg::KindSep, p, exprtok_pkg::ErrNone);
      exprtok_pkg::CharNul:    add_single(exprtok_pkg::KindEnd, p, exprtok_pkg::ErrNone);
      exprtok_pkg::CharPlus, exprtok_pkg::CharMinus, exprtok_pkg::CharStar,
      exprtok_pkg::CharCaret:
        add_single(exprtok_pkg::KindSymbol, p, exprtok_pkg::ErrNone);
      default: begin
        if (ch_alpha(c) || c == exprtok_pkg::CharUnder) begin
          open_token(exprtok_pkg::ModeName, p);
        end else if (ch_digit(c)) begin
          open_token(exprtok_pkg::ModeDec, p);
          lex_radix = exprtok_pkg::radix_t'(c - exprtok_pkg::CharZero);
        end else begin
          add_single(exprtok_pkg::KindEnd, p, exprtok_pkg::ErrUnknown);
          lex_mode = exprtok_pkg::ModeError;
        end
      end
    endcase
  endfunction

  function automatic void lex_char(exprtok_pkg::char_t c);
    exprtok_pkg::field_t p;
    bit                  relex;
    bit                  base_ok;
    p = lex_pos;
    relex = 1'b0;
    base_ok = ch_digit(c) &&
              ((int'(c) - int'(exprtok_pkg::CharZero)) < int'(lex_radix));
    step_tokens.delete();
    case (lex_mode)
      exprtok_pkg::ModeName: begin
        if (ch_alpha(c) || ch_digit(c) || c == exprtok_pkg::CharUnder) begin
          grow_len();
        end else begin
          add_token(exprtok_pkg::KindName, lex_begin, lex_len, exprtok_pkg::RadixNone,
                    exprtok_pkg::ErrNone);
          relex = 1'b1;
        end
      end
      exprtok_pkg::ModeDec: begin
        if (ch_digit(c)) begin
          grow_len();
        end else if (c == exprtok_pkg::CharDot && !lex_frac) begin
          lex_frac = 1'b1;
          grow_len();
        end else if (c == exprtok_pkg::CharLowX && lex_len == 16'd1 && !lex_frac) begin
          grow_len();
          if (lex_radix == exprtok_pkg::RadixNone) begin
            lex_radix = exprtok_pkg::RadixHex;
            lex_mode = exprtok_pkg::ModeHexStart;
          end else begin
            lex_mode = exprtok_pkg::ModeBaseStart;
          end
        end else begin
          add_token(exprtok_pkg::KindNumber, lex_begin, lex_len, exprtok_pkg::RadixDec,
                    exprtok_pkg::ErrNone);
          relex = 1'b1;
        end
      end
      exprtok_pkg::ModeHexStart: begin
        if (ch_hex(c)) begin
          grow_len();
          lex_mode = exprtok_pkg::ModeHex;
        end else begin
          add_token(exprtok_pkg::KindEnd, lex_begin, lex_len, exprtok_pkg::RadixNone,
                    exprtok_pkg::ErrUnknown);
          lex_mode = exprtok_pkg::ModeError;
        end
      end
      exprtok_pkg::ModeHex: begin
        if (ch_hex(c)) begin
          grow_len();
        end else if (c == exprtok_pkg::CharDot && !lex_frac) begin
          lex_frac = 1'b1;
          grow_len();
        end else begin
          add_token(exprtok_pkg::KindNumber, lex_begin, lex_len, exprtok_pkg::RadixHex,
                    exprtok_pkg::ErrNone);
          relex = 1'b1;
        end
      end
      exprtok_pkg::ModeBaseStart, exprtok_pkg::ModeBaseN: begin
        if (base_ok) begin
          grow_len();
          lex_mode = exprtok_pkg::ModeBaseN;
        end else if (c == exprtok_pkg::CharDot && lex_mode == exprtok_pkg::ModeBaseN &&
                     !lex_frac) begin
          lex_frac = 1'b1;
          grow_len();
        end else if (ch_hex(c)) begin
          add_single(exprtok_pkg::KindEnd, p, exprtok_pkg::ErrBadDigit);
          lex_mode = exprtok_pkg::ModeError;
        end else begin
          add_token(exprtok_pkg::KindNumber, lex_begin, lex_len, lex_radix,
                    exprtok_pkg::ErrNone);
          relex = 1'b1;
        end
      end
      exprtok_pkg::ModeError: begin
        if (c == exprtok_pkg::CharNul)
          add_single(exprtok_pkg::KindEnd, p, exprtok_pkg::ErrNone);
      end
      default: relex = 1'b1;
    endcase
    if (relex) lex_fresh(c, p);
    if (c == exprtok_pkg::CharNul) begin
      lex_mode = exprtok_pkg::ModeIdle;
      lex_pos = '0;
    end else begin
      lex_pos = p + 16'd1;
    end
    foreach (step_tokens[i])
      pending_tokens.push_back(token_beat_t'{res: step_tokens[i],
                                             last: (i == step_tokens.size() - 1)});
  endfunction

  task automatic send_char(input exprtok_pkg::char_t c);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      char_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_bus.valid = 1'b1;
    char_bus.char_in = c;
    do @(posedge clk); while (char_bus.ready !== 1'b1);
    lex_char(c);
  endtask

  task automatic send_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) send_char(exprtok_pkg::char_t'(s[i]));
    if (terminate) send_char(exprtok_pkg::CharNul);
  endtask

  // Every token kind, both error kinds, and the recovery paths after an error.
  task automatic test_directed();
    send_text("(_Z9,0xf.A*5x^3x2.1-7.5.", 1'b1);
    send_text(" )+", 1'b0);
    send_char(exprtok_pkg::CharCr);
    send_text("2x5", 1'b1);
    send_text("0x", 1'b1);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(exprtok_pkg::CharNul);
  endtask

  // Two token beats per character pair while the sink holds off.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 300;
    repeat (20) send_text("x)1,", 1'b0);
    send_char(exprtok_pkg::CharNul);
    gaps_on = 1'b1;
  endtask

  // A long name sent back to back, closed by a blank and an operator.
  task automatic test_long_token();
    gaps_on = 1'b0;
    send_char(exprtok_pkg::CharUnder);
    repeat (200) send_char(pick(NameSet));
    send_text(" +", 1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned base_n;
    sent = 0;
    while (sent < 1620) begin
      expr_chars.delete();
      repeat ($urandom_range(0, 14)) begin
        if ($urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 3)) expr_chars.push_back(pick(BlankSet));
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            expr_chars.push_back(pick(LeadSet));
            repeat ($urandom_range(0, 7)) expr_chars.push_back(pick(NameSet));
          end
          4, 5, 6, 7: begin
            repeat ($urandom_range(1, 5)) expr_chars.push_back(pick(DecSet));
            if ($urandom_range(0, 2) == 0) begin
              expr_chars.push_back(exprtok_pkg::CharDot);
              repeat ($urandom_range(0, 3)) expr_chars.push_back(pick(DecSet));
              if ($urandom_range(0, 9) == 0) expr_chars.push_back(exprtok_pkg::CharDot);
            end
          end
          8, 9: begin
            expr_chars.push_back(exprtok_pkg::CharZero);
            expr_chars.push_back(exprtok_pkg::CharLowX);
            repeat ($urandom_range(0, 4)) expr_chars.push_back(pick(HexSet));
            if ($urandom_range(0, 3) == 0) begin
              expr_chars.push_back(exprtok_pkg::CharDot);
              repeat ($urandom_range(0, 3)) expr_chars.push_back(pick(HexSet));
            end
          end
          10, 11, 12: begin
            base_n = $urandom_range(1, 9);
            expr_chars.push_back(exprtok_pkg::char_t'(exprtok_pkg::CharZero + base_n));
            expr_chars.push_back(exprtok_pkg::CharLowX);
            repeat ($urandom_range(0, 4))
              expr_chars.push_back(exprtok_pkg::char_t'(exprtok_pkg::CharZero +
                                                        $urandom_range(0, base_n - 1)));
            if ($urandom_range(0, 2) == 0) begin
              expr_chars.push_back(exprtok_pkg::CharDot);
              repeat ($urandom_range(0, 3))
                expr_chars.push_back(exprtok_pkg::char_t'(exprtok_pkg::CharZero +
                                                          $urandom_range(0, base_n - 1)));
            end
            if ($urandom_range(0, 7) == 0) expr_chars.push_back(pick(HexSet));
          end
          13, 14, 15, 16, 17, 18: expr_chars.push_back(pick(OpSet));
          default: expr_chars.push_back(exprtok_pkg::char_t'($urandom_range(0, 255)));
        endcase
      end
      expr_chars.push_back(exprtok_pkg::CharNul);
      foreach (expr_chars[i]) send_char(expr_chars[i]);
      sent += expr_chars.size();
    end
  endtask

  initial begin : token_sink
    int unsigned phase_left;
    int unsigned stall_pct;
    int unsigned hold_left;
    phase_left = 0;
    stall_pct = 0;
    hold_left = 0;
    tok_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        tok_bus.ready = 1'b0;
      end else begin
        tok_bus.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic check_beat();
    token_beat_t want;
    if (pending_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token beat: kind %0d start %0d length %0d radix %0d err %0d",
                 tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length,
                 tok_bus.number_radix, tok_bus.error_code);
      return;
    end
    want = pending_tokens.pop_front();
    if (tok_bus.token_kind !== want.res.kind || tok_bus.token_start !== want.res.start ||
        tok_bus.token_length !== want.res.length || tok_bus.number_radix !== want.res.radix ||
        tok_bus.error_code !== want.res.err || tok_bus.last_of_run !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("token mismatch: expected kind %0d start %0d length %0d radix %0d",
                 want.res.kind, want.res.start, want.res.length, want.res.radix);
        $display("                expected err %0d last %0b", want.res.err, want.last);
        $display("                got      kind %0d start %0d length %0d radix %0d",
                 tok_bus.token_kind, tok_bus.token_start, tok_bus.token_length,
                 tok_bus.number_radix);
        $display("                got      err %0d last %0b",
                 tok_bus.error_code, tok_bus.last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1) check_beat();
  end

  initial begin
    int unsigned waited;
    rst_n = 1'b0;
    char_bus.valid = 1'b0;
    char_bus.char_in = exprtok_pkg::CharNul;
    lex_mode = exprtok_pkg::ModeIdle;
    lex_pos = '0;
    lex_begin = '0;
    lex_len = '0;
    lex_radix = exprtok_pkg::RadixNone;
    lex_frac = 1'b0;
    mismatches = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_request = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_long_token();
    test_random();

    @(negedge clk);
    char_bus.valid = 1'b0;
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $display("%0d predicted token beats never arrived", pending_tokens.size());
      mismatches += pending_tokens.size();
    end
    if (mismatches == 0) begin
      $display("expression_tokenizer regression: pass");
    end else begin
      $display("expression_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
